>>> src/mlpsig_pkg.sv
// shared types, constants and arithmetic helpers of the sigmoid mlp block
// used by mlpsig_ctrl, mlpsig_dp and mlp_sigmoid_train_infer_top
package mlpsig_pkg;

	localparam int NF = 8;
	localparam int NH = 8;
	localparam int NW = NH * (NF + 1) + NH + 1;
	localparam int OUT_BASE = NH * (NF + 1);
	localparam int AW = $clog2(NW);
	localparam int FW = (NF > 1) ? $clog2(NF) : 1;
	localparam int HW = (NH > 1) ? $clog2(NH) : 1;
	localparam int CW = $clog2(((NF > NH) ? NF : NH) + 1);
	localparam int DW = 16;
	localparam int SW = 12;
	localparam int LRW = 12;
	localparam int PW = 50;
	localparam int ACCW = 40;
	localparam int OPA_W = 26;
	localparam int OPB_W = 24;
	localparam logic [LRW-1:0] LR_RESET = 12'd1229;

	typedef enum logic [2:0] {
		OP_LOAD  = 3'd0,
		OP_INFER = 3'd1,
		OP_TRAIN = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	typedef enum logic [4:0] {
		P_NOP, P_CLR, P_MACX, P_MACH, P_BIAS, P_RND, P_SIGH, P_SIGO,
		P_DO1, P_DO2, P_DH1, P_DH2, P_DH3, P_CF, P_UPDX, P_UPDH, P_UPDB, P_RDW
	} pop_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_HCLR, ST_HMAC, ST_HRND, ST_HSIG, ST_OCLR, ST_OMAC,
		ST_ORND, ST_OSIG, ST_DO1, ST_DO2, ST_DH1, ST_DH2, ST_DH3, ST_HCF, ST_HUPD,
		ST_OCF, ST_OUPD, ST_DONE
	} state_t;

	typedef struct packed {
		pop_t           pop;
		logic [AW-1:0]  addr;
		logic [FW-1:0]  fidx;
		logic [HW-1:0]  hidx;
		logic           use_do;
	} pipe_t;

	typedef struct packed {
		logic  load_item;
		logic  feat_we;
		logic  wr_direct;
		logic  res_load;
		pipe_t p;
	} dp_cmd_t;

	typedef struct packed {
		logic busy;
		op_t  op;
		logic feat_ok;
		logic w_ok;
	} dp_stat_t;

	// sigmoid at k/2 in q0.12
	function automatic logic [SW-1:0] sig_point(input logic [4:0] k);
		logic [SW-1:0] r;
		case (k)
			5'd0:    r = 12'd2048;
			5'd1:    r = 12'd2550;
			5'd2:    r = 12'd2994;
			5'd3:    r = 12'd3349;
			5'd4:    r = 12'd3608;
			5'd5:    r = 12'd3785;
			5'd6:    r = 12'd3902;
			5'd7:    r = 12'd3976;
			5'd8:    r = 12'd4022;
			5'd9:    r = 12'd4051;
			5'd10:   r = 12'd4069;
			5'd11:   r = 12'd4079;
			5'd12:   r = 12'd4086;
			5'd13:   r = 12'd4090;
			5'd14:   r = 12'd4092;
			5'd15:   r = 12'd4094;
			default: r = 12'd4095;
		endcase
		return r;
	endfunction

	// shift right by 24 or 12, rounding half away from zero
	function automatic logic signed [PW-1:0] rnd_p(input logic signed [PW-1:0] v,
			input logic sh24);
		logic signed [PW-1:0] mag;
		logic signed [PW-1:0] r;
		mag = v[PW-1] ? -v : v;
		if (sh24) begin
			r = (mag + (PW'(1) <<< 23)) >>> 24;
		end else begin
			r = (mag + (PW'(1) <<< 11)) >>> 12;
		end
		return v[PW-1] ? -r : r;
	endfunction

	function automatic logic signed [DW-1:0] sat16(input logic signed [PW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > PW'(32767)) begin
			r = 16'sh7fff;
		end else if (v < -PW'(32768)) begin
			r = 16'sh8000;
		end else begin
			r = v[DW-1:0];
		end
		return r;
	endfunction

endpackage

>>> src/mlpsig_dp.sv
// datapath: weight memory, feature buffer, shared multiplier pipeline, result register
// depends on mlpsig_pkg; driven by mlpsig_ctrl commands
module mlpsig_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlpsig_pkg::dp_cmd_t           cmd,
	output mlpsig_pkg::dp_stat_t          stat,
	input  logic [2:0]                    item_op,
	input  logic [8:0]                    item_index,
	input  logic signed [15:0]            item_value,
	input  logic                          item_target,
	input  logic                          cfg_we,
	input  logic [11:0]                   cfg_wdata,
	output logic                          res_class,
	output logic [11:0]                   res_score,
	output logic signed [15:0]            res_read,
	output logic                          res_error
);
	import mlpsig_pkg::*;

	logic [2:0]              op_q;
	logic [8:0]              idx_q;
	logic signed [DW-1:0]    val_q;
	logic                    tgt_q;
	logic [LRW-1:0]          lr_q;

	logic signed [DW-1:0]    wmem [NW];
	logic signed [DW-1:0]    rdata_s1;
	logic signed [DW-1:0]    feat_q [NF];

	pipe_t                   p_s1, p_s2;
	logic signed [PW-1:0]    prod_s2;
	logic signed [DW-1:0]    w_s2;
	logic [SW-1:0]           base_s2;
	logic                    neg_s2, sat_s2;

	logic signed [ACCW-1:0]  acc_q;
	logic signed [DW-1:0]    x_q;
	logic [SW-1:0]           h_q [NH];
	logic [SW-1:0]           s_q;
	logic [22:0]             tmp_q;
	logic signed [11:0]      do_q;
	logic signed [14:0]      t_q;
	logic signed [12:0]      dh_q [NH];
	logic signed [24:0]      coef_q;
	logic signed [DW-1:0]    rdv_q;

	logic [AW-1:0]           raddr, waddr;
	logic                    we;
	logic signed [DW-1:0]    wdata;
	logic signed [OPA_W-1:0] a_op;
	logic signed [OPB_W-1:0] b_op;
	logic [16:0]             xm;
	logic [3:0]              sidx;
	logic signed [13:0]      s14;
	logic signed [SW:0]      hs;
	logic [SW-1:0]           sig_base, sig_diff;
	logic signed [PW-1:0]    r24, r12, upd_sum;
	logic [SW-1:0]           sv, sig_out;
	logic signed [DW-1:0]    upd_val;
	logic                    err_c, net_c;

	// item and configuration
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q  <= item_op;
			idx_q <= item_index;
			val_q <= item_value;
			tgt_q <= item_target;
		end
		if (cmd.feat_we) begin
			feat_q[idx_q[FW-1:0]] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= LR_RESET;
			p_s1 <= '{pop: P_NOP, default: '0};
			p_s2 <= '{pop: P_NOP, default: '0};
		end else begin
			if (cfg_we) begin
				lr_q <= cfg_wdata;
			end
			p_s1 <= cmd.p;
			p_s2 <= p_s1;
		end
	end

	assign stat.busy    = (p_s1.pop != P_NOP) || (p_s2.pop != P_NOP);
	assign stat.op      = op_t'(op_q);
	assign stat.feat_ok = idx_q < 9'(NF);
	assign stat.w_ok    = idx_q < 9'(NW);

	// weight memory, one read and one write port, registered read
	assign raddr   = (cmd.p.pop == P_RDW) ? idx_q[AW-1:0] : cmd.p.addr;
	assign upd_sum = PW'(w_s2) + ((p_s2.pop == P_UPDB) ? r12 : r24);
	assign upd_val = sat16(upd_sum);
	assign we      = cmd.wr_direct || (p_s2.pop == P_UPDX) || (p_s2.pop == P_UPDH)
		|| (p_s2.pop == P_UPDB);
	assign waddr   = cmd.wr_direct ? idx_q[AW-1:0] : p_s2.addr;
	assign wdata   = cmd.wr_direct ? val_q : upd_val;

	always_ff @(posedge clk) begin
		rdata_s1 <= wmem[raddr];
		if (we) begin
			wmem[waddr] <= wdata;
		end
	end

	// sigmoid table lookup on the rounded pre-activation
	always_comb begin
		xm       = x_q[DW-1] ? (17'd0 - 17'(x_q)) : 17'(x_q);
		sidx     = xm[14:11];
		sig_base = xm[16:15] != 2'b00 ? sig_point(5'd16) : sig_point({1'b0, sidx});
		sig_diff = sig_point(5'({1'b0, sidx}) + 5'd1) - sig_point({1'b0, sidx});
		s14      = 14'(signed'({1'b0, s_q}));
		hs       = signed'({1'b0, h_q[p_s1.hidx]});
	end

	// operand select for the shared multiplier
	always_comb begin
		a_op = '0;
		b_op = '0;
		case (p_s1.pop)
			P_MACX: begin
				a_op = OPA_W'(feat_q[p_s1.fidx]);
				b_op = OPB_W'(rdata_s1);
			end
			P_MACH: begin
				a_op = OPA_W'(hs);
				b_op = OPB_W'(rdata_s1);
			end
			P_SIGH, P_SIGO: begin
				a_op = OPA_W'(signed'({1'b0, sig_diff}));
				b_op = OPB_W'(signed'({1'b0, xm[10:0]}));
			end
			P_DO1: begin
				a_op = OPA_W'(s14);
				b_op = OPB_W'(14'sd4096 - s14);
			end
			P_DO2: begin
				a_op = OPA_W'(tgt_q ? (14'sd4096 - s14) : -s14);
				b_op = OPB_W'(signed'({1'b0, tmp_q}));
			end
			P_DH1: begin
				a_op = OPA_W'(do_q);
				b_op = OPB_W'(rdata_s1);
			end
			P_DH2: begin
				a_op = OPA_W'(hs);
				b_op = OPB_W'(14'sd4096 - 14'(hs));
			end
			P_DH3: begin
				a_op = OPA_W'(t_q);
				b_op = OPB_W'(signed'({1'b0, tmp_q}));
			end
			P_CF: begin
				a_op = OPA_W'(signed'({1'b0, lr_q}));
				b_op = p_s1.use_do ? OPB_W'(do_q) : OPB_W'(dh_q[p_s1.hidx]);
			end
			P_UPDX: begin
				a_op = OPA_W'(coef_q);
				b_op = OPB_W'(feat_q[p_s1.fidx]);
			end
			P_UPDH: begin
				a_op = OPA_W'(coef_q);
				b_op = OPB_W'(hs);
			end
			P_UPDB: begin
				a_op = OPA_W'(coef_q);
				b_op = OPB_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PW'(a_op) * PW'(b_op);
		w_s2    <= rdata_s1;
		base_s2 <= sig_base;
		sat_s2  <= xm[16:15] != 2'b00;
		neg_s2  <= x_q[DW-1];
	end

	// writeback stage
	assign r24 = rnd_p(prod_s2, 1'b1);
	assign r12 = rnd_p(prod_s2, 1'b0);

	always_comb begin
		sv      = sat_s2 ? base_s2 : (base_s2 + SW'((prod_s2 + PW'(1024)) >>> 11));
		sig_out = neg_s2 ? SW'(13'd4096 - 13'(sv)) : sv;
	end

	always_ff @(posedge clk) begin
		case (p_s2.pop) inside
			P_CLR:          acc_q <= '0;
			P_MACX, P_MACH: acc_q <= acc_q + prod_s2[ACCW-1:0];
			P_BIAS:         acc_q <= acc_q + (ACCW'(w_s2) <<< 12);
			P_RND:          x_q <= sat16(rnd_p(PW'(acc_q), 1'b0));
			P_SIGH:         h_q[p_s2.hidx] <= sig_out;
			P_SIGO:         s_q <= sig_out;
			P_DO1, P_DH2:   tmp_q <= prod_s2[22:0];
			P_DO2:          do_q <= r24[11:0];
			P_DH1:          t_q <= r12[14:0];
			P_DH3:          dh_q[p_s2.hidx] <= r24[12:0];
			P_CF:           coef_q <= prod_s2[24:0];
			P_RDW:          rdv_q <= w_s2;
			default: ;
		endcase
	end

	// result word
	always_comb begin
		net_c = (op_q == OP_INFER) || (op_q == OP_TRAIN);
		case (op_q) inside
			OP_LOAD:           err_c = !stat.feat_ok;
			OP_WRITE, OP_READ: err_c = !stat.w_ok;
			OP_INFER, OP_TRAIN: err_c = 1'b0;
			default:           err_c = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_class <= net_c && (s_q > 12'd2048);
			res_score <= net_c ? s_q : '0;
			res_read  <= ((op_q == OP_READ) && stat.w_ok) ? rdv_q : '0;
			res_error <= err_c;
		end
	end

endmodule

>>> src/mlpsig_ctrl.sv
// controller: sequences forward pass, deltas and weight updates over the datapath
// depends on mlpsig_pkg; owns the stream handshakes
module mlpsig_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  mlpsig_pkg::dp_stat_t  stat,
	output mlpsig_pkg::dp_cmd_t   cmd
);
	import mlpsig_pkg::*;

	state_t        state_q, state_d;
	logic [CW-1:0] i_q, i_d, j_q, j_d;
	logic          ov_q;
	logic          out_free, need_idle, go;
	logic [AW-1:0] haddr, oaddr, dhaddr;

	assign out_free  = !ov_q || m_tready;
	// these steps read what the step before wrote, so the pipe must drain
	assign need_idle = (state_q inside {ST_HRND, ST_HSIG, ST_OCLR, ST_ORND, ST_OSIG, ST_DO1,
		ST_DO2, ST_DH1, ST_DH3, ST_HCF, ST_OCF, ST_DONE})
		|| ((state_q == ST_HUPD || state_q == ST_OUPD) && j_q == '0);
	assign go = !(need_idle && stat.busy) && (state_q != ST_DONE || out_free);

	assign haddr  = AW'(i_q * (NF + 1)) + AW'(j_q);
	assign oaddr  = AW'(OUT_BASE) + AW'(j_q);
	assign dhaddr = AW'(OUT_BASE) + AW'(i_q);

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			if (cmd.res_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		if (go) begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_d = ST_DECODE;
				end
				ST_DECODE: begin
					i_d = '0;
					j_d = '0;
					if (stat.op == OP_INFER || stat.op == OP_TRAIN) begin
						state_d = ST_HCLR;
					end else begin
						state_d = ST_DONE;
					end
				end
				ST_HCLR: begin
					j_d     = '0;
					state_d = ST_HMAC;
				end
				ST_HMAC: begin
					if (j_q == CW'(NF)) state_d = ST_HRND;
					else j_d = j_q + 1'b1;
				end
				ST_HRND: state_d = ST_HSIG;
				ST_HSIG: begin
					if (i_q == CW'(NH - 1)) begin
						i_d     = '0;
						state_d = ST_OCLR;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_HCLR;
					end
				end
				ST_OCLR: begin
					j_d     = '0;
					state_d = ST_OMAC;
				end
				ST_OMAC: begin
					if (j_q == CW'(NH)) state_d = ST_ORND;
					else j_d = j_q + 1'b1;
				end
				ST_ORND: state_d = ST_OSIG;
				ST_OSIG: state_d = (stat.op == OP_TRAIN) ? ST_DO1 : ST_DONE;
				ST_DO1:  state_d = ST_DO2;
				ST_DO2: begin
					i_d     = '0;
					state_d = ST_DH1;
				end
				ST_DH1: state_d = ST_DH2;
				ST_DH2: state_d = ST_DH3;
				ST_DH3: begin
					if (i_q == CW'(NH - 1)) begin
						i_d     = '0;
						state_d = ST_HCF;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = ST_DH1;
					end
				end
				ST_HCF: begin
					j_d     = '0;
					state_d = ST_HUPD;
				end
				ST_HUPD: begin
					if (j_q == CW'(NF)) begin
						if (i_q == CW'(NH - 1)) begin
							i_d     = '0;
							state_d = ST_OCF;
						end else begin
							i_d     = i_q + 1'b1;
							state_d = ST_HCF;
						end
					end else begin
						j_d = j_q + 1'b1;
					end
				end
				ST_OCF: begin
					j_d     = '0;
					state_d = ST_OUPD;
				end
				ST_OUPD: begin
					if (j_q == CW'(NH)) state_d = ST_DONE;
					else j_d = j_q + 1'b1;
				end
				ST_DONE: state_d = ST_IDLE;
				default: state_d = ST_IDLE;
			endcase
		end
	end

	// commands
	always_comb begin
		cmd           = '0;
		cmd.p.pop     = P_NOP;
		cmd.load_item = s_tvalid && s_tready;
		if (go) begin
			unique case (state_q)
				ST_DECODE: begin
					cmd.feat_we   = (stat.op == OP_LOAD) && stat.feat_ok;
					cmd.wr_direct = (stat.op == OP_WRITE) && stat.w_ok;
					if ((stat.op == OP_READ) && stat.w_ok) cmd.p.pop = P_RDW;
				end
				ST_HCLR, ST_OCLR: cmd.p.pop = P_CLR;
				ST_HMAC: begin
					cmd.p.pop  = (j_q == CW'(NF)) ? P_BIAS : P_MACX;
					cmd.p.addr = haddr;
					cmd.p.fidx = j_q[FW-1:0];
				end
				ST_HRND, ST_ORND: cmd.p.pop = P_RND;
				ST_HSIG: begin
					cmd.p.pop  = P_SIGH;
					cmd.p.hidx = i_q[HW-1:0];
				end
				ST_OMAC: begin
					cmd.p.pop  = (j_q == CW'(NH)) ? P_BIAS : P_MACH;
					cmd.p.addr = oaddr;
					cmd.p.hidx = j_q[HW-1:0];
				end
				ST_OSIG: cmd.p.pop = P_SIGO;
				ST_DO1:  cmd.p.pop = P_DO1;
				ST_DO2:  cmd.p.pop = P_DO2;
				ST_DH1: begin
					cmd.p.pop  = P_DH1;
					cmd.p.addr = dhaddr;
				end
				ST_DH2: begin
					cmd.p.pop  = P_DH2;
					cmd.p.hidx = i_q[HW-1:0];
				end
				ST_DH3: begin
					cmd.p.pop  = P_DH3;
					cmd.p.hidx = i_q[HW-1:0];
				end
				ST_HCF: begin
					cmd.p.pop  = P_CF;
					cmd.p.hidx = i_q[HW-1:0];
				end
				ST_HUPD: begin
					cmd.p.pop  = (j_q == CW'(NF)) ? P_UPDB : P_UPDX;
					cmd.p.addr = haddr;
					cmd.p.fidx = j_q[FW-1:0];
				end
				ST_OCF: begin
					cmd.p.pop    = P_CF;
					cmd.p.use_do = 1'b1;
				end
				ST_OUPD: begin
					cmd.p.pop  = (j_q == CW'(NH)) ? P_UPDB : P_UPDH;
					cmd.p.addr = oaddr;
					cmd.p.hidx = j_q[HW-1:0];
				end
				ST_DONE: cmd.res_load = 1'b1;
				default: ;
			endcase
		end
	end

endmodule

>>> src/mlp_sigmoid_train_infer_top.sv
// top level of the one-hidden-layer sigmoid mlp with on-line training
// depends on mlpsig_pkg, mlpsig_ctrl and mlpsig_dp
//
// Usage:
//   slave stream takes one command word per handshake; tuser carries the operation
//   (load feature, infer, train, write weight, read weight), tdata the index, value
//   and target. every word gives exactly one result word on the master stream, with
//   class bit, score and read value in tdata and the error flag in tuser.
//   learning rate is written through cfg_we/cfg_wdata while the block is idle.
// Processing:
//   every weight goes through the one shared multiplier, once for the forward pass and,
//   in train, once more for the update, with a three-stage memory/multiply/writeback
//   pipe that drains between dependent steps (pre-activation rounding, sigmoid, deltas).
//   one word is worked at a time; s_tready is high only when the sequencer is idle.
// Reset and stall:
//   arst_n clears the sequencer, output valid and sets the learning rate to 1229;
//   weights and features hold nothing defined until written.
//   a stalled result waits in the output register; the next word is accepted
//   meanwhile, and its result waits until the held one is taken.
module mlp_sigmoid_train_infer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // index[8:0], value[24:9], target[25], zero above
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // class_bit[0], score[12:1], read_value[28:13], zero above
	output logic [0:0]  m_tuser,   // error[0]
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);
	import mlpsig_pkg::*;

	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic               res_class, res_error;
	logic [11:0]        res_score;
	logic signed [15:0] res_read;

	mlpsig_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mlpsig_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.item_op     (s_tuser),
		.item_index  (s_tdata[8:0]),
		.item_value  (s_tdata[24:9]),
		.item_target (s_tdata[25]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.res_class   (res_class),
		.res_score   (res_score),
		.res_read    (res_read),
		.res_error   (res_error)
	);

	assign m_tdata = {3'b000, res_read, res_score, res_class};
	assign m_tuser = res_error;

	a_accept_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !stat.busy)
		else $error("word accepted with datapath pipe busy");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while held");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> m_tvalid)
		else $error("loaded result not presented");

endmodule
